FILE: src/hrc_pkg.sv
// ----------------------------------------------------------------------------
// hrc_pkg: shared types and constants for the history ring
// Item structs, operation and status codes, sequencer states and ring math.
// ----------------------------------------------------------------------------
package hrc_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 32;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_PREV   = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_AT_OLDEST = 3'd2,
    STAT_NEED_NEW  = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_COPY,
    S_RESP
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  entry_id;
    logic [ID_W-1:0]  current_id;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   entry_value;
    logic [CNT_W-1:0]  entry_count;
    logic [ADDR_W-1:0] cursor_position;
  } out_item_t;

  // Add two slot indexes modulo DEPTH.
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W + 1)'(DEPTH)) begin
      s = s - (ADDR_W + 1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  // Physical slot of the oldest valid entry.
  function automatic logic [ADDR_W-1:0] oldest_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  count);
    logic [CNT_W-1:0] back;
    back = CNT_W'(DEPTH) - count;
    if ((count == '0) || (back == '0)) begin
      return head;
    end
    return wrap_add(head, back[ADDR_W-1:0]);
  endfunction

endpackage

FILE: src/hrc_ram.sv
// ----------------------------------------------------------------------------
// hrc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/history_ring_with_cursor.sv
// ----------------------------------------------------------------------------
// history_ring_with_cursor: navigation history ring with a logical cursor
// Append, prev, next and remove-with-compaction over a ring of entry IDs.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one command item (kind, entry_id,
//   current_id); out_valid/out_ready/out_data return exactly one result item
//   per command (status, entry_value, entry_count, cursor_position).
//   One command is in work at a time; in_ready is high only while the
//   sequencer is idle, which it is again in the cycle that out_valid rises.
// Sequence from accept to out_valid (output register free):
//   append, or prev/next that fail: straight to the result state.
//   prev/next that move the cursor: one ring read in S_FETCH first.
//   remove: one pass over the ring (S_SCAN) when the ID is absent, and
//   a second pass (S_COPY) after it when found. The single ring read port
//   sets this: one pass reads every valid entry and writes the survivors
//   into a scratch RAM, a second pass copies survivors back to slots 0..
// Reset (rst_n low, synchronous): empty history, head and cursor at 0.
//   Ring contents are not cleared; only valid slots are ever read.
// Stall: a finished result waits in the output register while the next
//   command is accepted; a second result then holds the sequencer until the
//   receiver takes the first.
// ----------------------------------------------------------------------------
module history_ring_with_cursor
  import hrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Control state
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  scan_i_r, scan_i_nxt;   // pass index, shared by scan and copy
  logic              pend_r, pend_nxt;       // a RAM read is in flight
  logic              found_r, found_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;             // survivor count
  logic              cur_hit_r, cur_hit_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ID_W-1:0]   cur_id_r, cur_id_nxt;
  logic [ADDR_W-1:0] cur_idx_r, cur_idx_nxt;
  logic [ADDR_W-1:0] copy_wa_r, copy_wa_nxt;
  out_item_t         res_r, res_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // RAM ports
  logic              ring_we;
  logic [ADDR_W-1:0] ring_waddr, ring_raddr;
  logic [ID_W-1:0]   ring_wdata, ring_rdata;
  logic              scr_we;
  logic [ADDR_W-1:0] scr_waddr, scr_raddr;
  logic [ID_W-1:0]   scr_wdata, scr_rdata;

  logic [ADDR_W-1:0] oldest;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  cursor_ext;

  hrc_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  hrc_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_scratch (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  assign oldest     = oldest_of(head_r, count_r);
  assign count_inc  = (count_r < CNT_W'(DEPTH)) ? (count_r + CNT_W'(1)) : count_r;
  assign cursor_ext = CNT_W'(cursor_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    scan_i_nxt    = scan_i_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    n_nxt         = n_r;
    cur_hit_nxt   = cur_hit_r;
    out_valid_nxt = out_valid_r;
    id_nxt        = id_r;
    cur_id_nxt    = cur_id_r;
    cur_idx_nxt   = cur_idx_r;
    copy_wa_nxt   = copy_wa_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;

    ring_we    = 1'b0;
    ring_waddr = head_r;
    ring_wdata = in_data.entry_id;
    ring_raddr = wrap_add(oldest, scan_i_r[ADDR_W-1:0]);
    scr_we     = 1'b0;
    scr_waddr  = n_r[ADDR_W-1:0];
    scr_wdata  = ring_rdata;
    scr_raddr  = scan_i_r[ADDR_W-1:0];

    // Drop the result once the receiver takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt     = in_data.entry_id;
          cur_id_nxt = in_data.current_id;
          state_nxt  = S_RESP;
          res_nxt    = '{STAT_OK, '0, count_r, cursor_r};
          case (in_data.kind)
            KIND_APPEND: begin
              // Write at the head; a full ring drops its oldest entry.
              ring_we    = 1'b1;
              head_nxt   = wrap_add(head_r, ADDR_W'(1));
              count_nxt  = count_inc;
              cursor_nxt = ADDR_W'(count_inc - CNT_W'(1));
              res_nxt    = '{STAT_OK, '0, count_inc, ADDR_W'(count_inc - CNT_W'(1))};
            end
            KIND_PREV: begin
              if (count_r == '0) begin
                res_nxt.status = STAT_EMPTY;
              end else if (cursor_r == '0) begin
                res_nxt.status = STAT_AT_OLDEST;
              end else begin
                cursor_nxt = cursor_r - ADDR_W'(1);
                ring_raddr = wrap_add(oldest, cursor_r - ADDR_W'(1));
                state_nxt  = S_FETCH;
              end
            end
            KIND_NEXT: begin
              if ((count_r == '0) || ((cursor_ext + CNT_W'(1)) >= count_r)) begin
                res_nxt.status = STAT_NEED_NEW;
              end else begin
                cursor_nxt = cursor_r + ADDR_W'(1);
                ring_raddr = wrap_add(oldest, cursor_r + ADDR_W'(1));
                state_nxt  = S_FETCH;
              end
            end
            KIND_REMOVE: begin
              scan_i_nxt  = '0;
              pend_nxt    = 1'b0;
              found_nxt   = 1'b0;
              n_nxt       = '0;
              cur_hit_nxt = 1'b0;
              state_nxt   = S_SCAN;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_FETCH: begin
        res_nxt   = '{STAT_OK, ring_rdata, count_r, cursor_r};
        state_nxt = S_RESP;
      end

      S_SCAN: begin
        // Issue the next oldest-first read while the previous one resolves.
        if (scan_i_r < count_r) begin
          scan_i_nxt = scan_i_r + CNT_W'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (ring_rdata == id_r) begin
            found_nxt = 1'b1;
          end else begin
            scr_we = 1'b1;
            n_nxt  = n_r + CNT_W'(1);
            if (!cur_hit_r && (ring_rdata == cur_id_r)) begin
              cur_hit_nxt = 1'b1;
              cur_idx_nxt = n_r[ADDR_W-1:0];
            end
          end
        end
        if ((scan_i_r == count_r) && !pend_r) begin
          if (!found_r) begin
            res_nxt   = '{STAT_NOT_FOUND, '0, count_r, cursor_r};
            state_nxt = S_RESP;
          end else begin
            scan_i_nxt = '0;
            state_nxt  = S_COPY;
          end
        end
      end

      S_COPY: begin
        // Move survivors back to slots 0..n-1.
        if (scan_i_r < n_r) begin
          scan_i_nxt  = scan_i_r + CNT_W'(1);
          copy_wa_nxt = scan_i_r[ADDR_W-1:0];
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ring_we    = 1'b1;
          ring_waddr = copy_wa_r;
          ring_wdata = scr_rdata;
        end
        if ((scan_i_r == n_r) && !pend_r) begin
          count_nxt = n_r;
          head_nxt  = n_r[ADDR_W-1:0];
          if (n_r == '0) begin
            cursor_nxt = '0;
          end else if (cur_hit_r) begin
            cursor_nxt = cur_idx_r;
          end else begin
            cursor_nxt = ADDR_W'(n_r - CNT_W'(1));
          end
          res_nxt   = '{STAT_OK, '0, n_r, cursor_nxt};
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      cursor_r    <= '0;
      scan_i_r    <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      n_r         <= '0;
      cur_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      scan_i_r    <= scan_i_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      n_r         <= n_nxt;
      cur_hit_r   <= cur_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    cur_id_r   <= cur_id_nxt;
    cur_idx_r  <= cur_idx_nxt;
    copy_wa_r  <= copy_wa_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above ring depth");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) ? (cursor_r == '0) : (cursor_ext < count_r))
    else $error("cursor outside valid entries");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in work");

  a_copy_has_removal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (found_r && (n_r < count_r)))
    else $error("compaction without a removed entry");
`endif

endmodule
